[src/e2q_pkg.sv]
package e2q_pkg;

    // Field widths and pipeline depth
    localparam int ANGLE_BITS     = 16;
    localparam int COMPONENT_BITS = 16;
    localparam int TRIG_STAGES    = 16;

    // Internal fixed point: Q2.30 sine, cosine and angle
    localparam int TRIG_W     = 32;
    localparam int Q_FRAC     = 30;
    localparam int Z_W        = TRIG_W + 2;
    localparam int Z_SHIFT    = TRIG_W - ANGLE_BITS;
    localparam int STAGE_W    = $clog2(TRIG_STAGES);
    localparam int ATAN_IDX_W = 5;

    // Axis slots
    localparam int NUM_AXES      = 3;
    localparam int AXIS_HEADING  = 0;
    localparam int AXIS_ATTITUDE = 1;
    localparam int AXIS_BANK     = 2;

    // Stream widths, padded to whole bytes
    localparam int S_TDATA_W = ((NUM_AXES * ANGLE_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = ((4 * COMPONENT_BITS + 7) / 8) * 8;

    // Output rounding and saturation
    localparam int OUT_SHIFT = TRIG_W - COMPONENT_BITS;

    typedef logic signed [ANGLE_BITS-1:0]     angle_t;
    typedef logic signed [TRIG_W-1:0]         trig_t;
    typedef logic signed [Z_W-1:0]            wide_t;
    typedef logic signed [COMPONENT_BITS-1:0] comp_t;
    typedef logic signed [2*TRIG_W-1:0]       prod_t;

    localparam trig_t CORDIC_GAIN = TRIG_W'(64'h26DD3B6A);
    localparam wide_t HALF_PI     = Z_W'(64'h6487ED51);
    localparam wide_t PI_Q30      = Z_W'(64'hC90FDAA2);
    localparam wide_t OUT_ROUND   = Z_W'((64'd1 << OUT_SHIFT) >> 1);
    localparam wide_t COMP_LIM    = Z_W'(64'd1 << (COMPONENT_BITS - 2));

    typedef angle_t [NUM_AXES-1:0] angle_set_t;

    // One axis in flight through the rotator
    typedef struct packed {
        trig_t x;
        trig_t y;
        trig_t z;
        logic  neg;
    } rot_t;

    typedef rot_t [NUM_AXES-1:0] rot_set_t;

    // Result; w sits in the lowest bits
    typedef struct packed {
        comp_t z;
        comp_t y;
        comp_t x;
        comp_t w;
    } quat_t;

    // Arctangent of 2^-i in Q2.30
    function automatic trig_t atan_q30(input logic [ATAN_IDX_W-1:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'h3243F6A8;
            5'd1:    v = 32'h1DAC6705;
            5'd2:    v = 32'h0FADBAFC;
            5'd3:    v = 32'h07F56EA6;
            5'd4:    v = 32'h03FEAB76;
            5'd5:    v = 32'h01FFD55B;
            5'd6:    v = 32'h00FFFAAA;
            5'd7:    v = 32'h007FFF55;
            5'd8:    v = 32'h003FFFEA;
            5'd9:    v = 32'h001FFFFD;
            5'd10:   v = 32'h000FFFFF;
            5'd11:   v = 32'h0007FFFF;
            5'd12:   v = 32'h0003FFFF;
            5'd13:   v = 32'h0001FFFF;
            5'd14:   v = 32'h0000FFFF;
            5'd15:   v = 32'h00007FFF;
            5'd16:   v = 32'h00003FFF;
            5'd17:   v = 32'h00001FFF;
            5'd18:   v = 32'h00000FFF;
            5'd19:   v = 32'h000007FF;
            5'd20:   v = 32'h000003FF;
            5'd21:   v = 32'h000001FF;
            5'd22:   v = 32'h000000FF;
            5'd23:   v = 32'h0000007F;
            5'd24:   v = 32'h0000003F;
            5'd25:   v = 32'h0000001F;
            5'd26:   v = 32'h0000000F;
            5'd27:   v = 32'h00000008;
            5'd28:   v = 32'h00000004;
            5'd29:   v = 32'h00000002;
            5'd30:   v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return trig_t'(v);
    endfunction

    // Q2.30 product, floor shift back to Q2.30
    function automatic trig_t mul_q30(input trig_t a, input trig_t b);
        prod_t p;
        p = a * b;
        return p[Q_FRAC +: TRIG_W];
    endfunction

    // Round half up to the output format and clamp to +-1.0
    function automatic comp_t round_sat(input wide_t v);
        wide_t r;
        r = (v + OUT_ROUND) >>> OUT_SHIFT;
        if (r > COMP_LIM) begin
            r = COMP_LIM;
        end else if (r < -COMP_LIM) begin
            r = -COMP_LIM;
        end
        return r[COMPONENT_BITS-1:0];
    endfunction

endpackage

[src/e2q_fold.sv]
module e2q_fold
    import e2q_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  angle_set_t in_angles,
    output logic       out_valid,
    input  logic       out_ready,
    output rot_set_t   out_data
);

    logic     valid_reg;
    rot_set_t data_reg;
    rot_set_t data_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Halve and scale to Q2.30, fold into the right half plane
    always_comb begin
        wide_t z0;
        wide_t z1;
        logic  neg;
        data_next = '0;
        for (int a = 0; a < NUM_AXES; a++) begin
            z0  = Z_W'(in_angles[a]) <<< Z_SHIFT;
            z1  = z0;
            neg = 1'b0;
            if (z0 > HALF_PI) begin
                z1  = z0 - PI_Q30;
                neg = 1'b1;
            end else if (z0 < -HALF_PI) begin
                z1  = z0 + PI_Q30;
                neg = 1'b1;
            end
            data_next[a].x   = CORDIC_GAIN;
            data_next[a].y   = '0;
            data_next[a].z   = z1[TRIG_W-1:0];
            data_next[a].neg = neg;
        end
    end

    // Advance when the next stage has room
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

[src/e2q_cordic_cell.sv]
module e2q_cordic_cell
    import e2q_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [STAGE_W-1:0] stage_idx,
    input  logic               in_valid,
    output logic               in_ready,
    input  rot_set_t           in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output rot_set_t           out_data
);

    logic     valid_reg;
    rot_set_t data_reg;
    rot_set_t data_next;
    trig_t    step_atan;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign step_atan = atan_q30(ATAN_IDX_W'(stage_idx));

    // One rotation step on all three axes, driven by the sign of z
    always_comb begin
        trig_t dx;
        trig_t dy;
        data_next = in_data;
        for (int a = 0; a < NUM_AXES; a++) begin
            dx = in_data[a].y >>> stage_idx;
            dy = in_data[a].x >>> stage_idx;
            if (!in_data[a].z[TRIG_W-1]) begin
                data_next[a].x = in_data[a].x - dx;
                data_next[a].y = in_data[a].y + dy;
                data_next[a].z = in_data[a].z - step_atan;
            end else begin
                data_next[a].x = in_data[a].x + dx;
                data_next[a].y = in_data[a].y - dy;
                data_next[a].z = in_data[a].z + step_atan;
            end
        end
    end

    // Hand the transaction to the neighbor
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

[src/e2q_combine.sv]
module e2q_combine
    import e2q_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  rot_set_t in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output quat_t    out_quat
);

    localparam int NSTG = 4;

    logic [NSTG-1:0] valid_reg;
    logic [NSTG-1:0] adv;

    // Stage 0: signed sine and cosine per axis
    trig_t ch_reg, sh_reg, ca_reg, sa_reg, cb_reg, sb_reg;
    trig_t ch_next, sh_next, ca_next, sa_next, cb_next, sb_next;

    // Stage 1: pair products, bank terms carried along
    trig_t chca_reg, shsa_reg, shca_reg, chsa_reg, cb1_reg, sb1_reg;

    // Stage 2: triple products
    trig_t t_w0_reg, t_w1_reg, t_x0_reg, t_x1_reg;
    trig_t t_y0_reg, t_y1_reg, t_z0_reg, t_z1_reg;

    // Stage 3: output register
    quat_t quat_reg;
    quat_t quat_next;

    // Each stage moves when the one after it has room
    always_comb begin
        adv[NSTG-1] = !valid_reg[NSTG-1] || out_ready;
        for (int i = NSTG - 2; i >= 0; i--) begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = valid_reg[NSTG-1];
    assign out_quat  = quat_reg;

    // Undo the range fold
    always_comb begin
        ch_next = in_data[AXIS_HEADING].neg  ? -in_data[AXIS_HEADING].x  : in_data[AXIS_HEADING].x;
        sh_next = in_data[AXIS_HEADING].neg  ? -in_data[AXIS_HEADING].y  : in_data[AXIS_HEADING].y;
        ca_next = in_data[AXIS_ATTITUDE].neg ? -in_data[AXIS_ATTITUDE].x : in_data[AXIS_ATTITUDE].x;
        sa_next = in_data[AXIS_ATTITUDE].neg ? -in_data[AXIS_ATTITUDE].y : in_data[AXIS_ATTITUDE].y;
        cb_next = in_data[AXIS_BANK].neg     ? -in_data[AXIS_BANK].x     : in_data[AXIS_BANK].x;
        sb_next = in_data[AXIS_BANK].neg     ? -in_data[AXIS_BANK].y     : in_data[AXIS_BANK].y;
    end

    // Sum, round and clamp the four components
    always_comb begin
        quat_next.w = round_sat(Z_W'(t_w0_reg) + Z_W'(t_w1_reg));
        quat_next.x = round_sat(Z_W'(t_x0_reg) - Z_W'(t_x1_reg));
        quat_next.y = round_sat(Z_W'(t_y0_reg) + Z_W'(t_y1_reg));
        quat_next.z = round_sat(Z_W'(t_z0_reg) - Z_W'(t_z1_reg));
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (adv[0]) begin
                valid_reg[0] <= in_valid;
            end
            for (int i = 1; i < NSTG; i++) begin
                if (adv[i]) begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (adv[0] && in_valid) begin
            ch_reg <= ch_next;
            sh_reg <= sh_next;
            ca_reg <= ca_next;
            sa_reg <= sa_next;
            cb_reg <= cb_next;
            sb_reg <= sb_next;
        end
        if (adv[1] && valid_reg[0]) begin
            chca_reg <= mul_q30(ch_reg, ca_reg);
            shsa_reg <= mul_q30(sh_reg, sa_reg);
            shca_reg <= mul_q30(sh_reg, ca_reg);
            chsa_reg <= mul_q30(ch_reg, sa_reg);
            cb1_reg  <= cb_reg;
            sb1_reg  <= sb_reg;
        end
        if (adv[2] && valid_reg[1]) begin
            t_w0_reg <= mul_q30(chca_reg, cb1_reg);
            t_w1_reg <= mul_q30(shsa_reg, sb1_reg);
            t_x0_reg <= mul_q30(shca_reg, cb1_reg);
            t_x1_reg <= mul_q30(chsa_reg, sb1_reg);
            t_y0_reg <= mul_q30(chsa_reg, cb1_reg);
            t_y1_reg <= mul_q30(shca_reg, sb1_reg);
            t_z0_reg <= mul_q30(chca_reg, sb1_reg);
            t_z1_reg <= mul_q30(shsa_reg, cb1_reg);
        end
        if (adv[3] && valid_reg[2]) begin
            quat_reg <= quat_next;
        end
    end

endmodule

[src/euler_to_quaternion.sv]
// Channel | Dir | Payload
// s_      | in  | tdata: heading_angle, attitude_angle, bank_angle (16 b each, Q2.13)
// m_      | out | tdata: quat_w, quat_x, quat_y, quat_z (16 b each, Q1.14)
//
// A transaction passes through the fold register, one CORDIC cell per stage, the
// fold undo, two multiply stages and the output register, each a single register.
// One transaction is accepted per cycle unless an m_ stall has filled every stage.
// Reset clears only the valid bits; payload registers keep their contents.
// A stall on m_ holds the output register and lets earlier stages fill up,
// so s_tready drops only when every stage holds a transaction.
module euler_to_quaternion
    import e2q_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // heading_angle, attitude_angle, bank_angle
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // quat_w, quat_x, quat_y, quat_z
);

    angle_set_t angles;
    quat_t      quat;

    logic     chain_valid [TRIG_STAGES+1];
    logic     chain_ready [TRIG_STAGES+1];
    rot_set_t chain_data  [TRIG_STAGES+1];

    // Unpack the input angles
    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            angles[a] = s_tdata[a*ANGLE_BITS +: ANGLE_BITS];
        end
    end

    e2q_fold u_fold (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_angles (angles),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_data  (chain_data[0])
    );

    // Row of rotation cells, one per CORDIC stage
    for (genvar i = 0; i < TRIG_STAGES; i++) begin : g_cell
        e2q_cordic_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .stage_idx (STAGE_W'(i)),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_data   (chain_data[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_data  (chain_data[i+1])
        );
    end

    e2q_combine u_combine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (chain_valid[TRIG_STAGES]),
        .in_ready  (chain_ready[TRIG_STAGES]),
        .in_data   (chain_data[TRIG_STAGES]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_quat  (quat)
    );

    // Pack the result, zero pad to whole bytes
    assign m_tdata = M_TDATA_W'(quat);

`ifndef ASSERT_OFF
    // Input side may only stall when the pipe is full behind a stalled output
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without an output stall");

    // Components stay within +-1.0
    a_sat_wx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (Z_W'(quat.w) <= COMP_LIM && Z_W'(quat.w) >= -COMP_LIM &&
                      Z_W'(quat.x) <= COMP_LIM && Z_W'(quat.x) >= -COMP_LIM))
        else $error("w or x component out of range");

    a_sat_yz: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (Z_W'(quat.y) <= COMP_LIM && Z_W'(quat.y) >= -COMP_LIM &&
                      Z_W'(quat.z) <= COMP_LIM && Z_W'(quat.z) >= -COMP_LIM))
        else $error("y or z component out of range");

    // A held result does not change under the output register
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready && s_tvalid && s_tready) |=> $stable(quat))
        else $error("stalled result changed while input advanced");
`endif

endmodule

[verif/euler_to_quaternion_tb.sv]
`timescale 1ns / 100ps

module euler_to_quaternion_tb
    import e2q_pkg::*;
();

    localparam int     PIPE_LAT    = TRIG_STAGES + 5;
    localparam int     RAND_ITEMS  = 1532;
    localparam int     CYCLE_LIMIT = 400000;
    localparam int     FOLD_EDGE   = 25736;
    localparam longint HALF_PI_RAD = 64'sh6487ED51;
    localparam longint PI_RAD      = 64'shC90FDAA2;
    localparam longint ROT_GAIN    = 64'sh26DD3B6A;
    localparam int     RND_SHIFT   = 32 - COMPONENT_BITS;
    localparam longint COMP_ONE    = 64'sd1 <<< (COMPONENT_BITS - 2);

    localparam longint ATAN_STEP [32] = '{
        64'sh3243F6A8, 64'sh1DAC6705, 64'sh0FADBAFC, 64'sh07F56EA6,
        64'sh03FEAB76, 64'sh01FFD55B, 64'sh00FFFAAA, 64'sh007FFF55,
        64'sh003FFFEA, 64'sh001FFFFD, 64'sh000FFFFF, 64'sh0007FFFF,
        64'sh0003FFFF, 64'sh0001FFFF, 64'sh0000FFFF, 64'sh00007FFF,
        64'sh00003FFF, 64'sh00001FFF, 64'sh00000FFF, 64'sh000007FF,
        64'sh000003FF, 64'sh000001FF, 64'sh000000FF, 64'sh0000007F,
        64'sh0000003F, 64'sh0000001F, 64'sh0000000F, 64'sh00000008,
        64'sh00000004, 64'sh00000002, 64'sh00000001, 64'sh00000000
    };

    // Directed angle triple; pin marks result fields given here (bit 0 = w)
    typedef struct packed {
        angle_t     h;
        angle_t     a;
        angle_t     b;
        logic [3:0] pin;
        quat_t      q;
    } stim_row_t;

    localparam int N_ROWS = 18;
    localparam stim_row_t DIR_ROWS [N_ROWS] = '{
        '{16'sd0,      16'sd0,      16'sd0,      4'b0001,
          '{z: 16'sd0, y: 16'sd0, x: 16'sd0, w: 16'sd16384}},
        '{16'sd32767,  16'sd32767,  16'sd32767,  4'b0000, '0},
        '{16'sh8000,   16'sh8000,   16'sh8000,   4'b0000, '0},
        '{16'sd32767,  16'sd0,      16'sd0,      4'b0000, '0},
        '{16'sd0,      16'sd32767,  16'sd0,      4'b0000, '0},
        '{16'sd0,      16'sd0,      16'sd32767,  4'b0000, '0},
        '{16'sh8000,   16'sd0,      16'sd0,      4'b0000, '0},
        '{16'sd0,      16'sh8000,   16'sd0,      4'b0000, '0},
        '{16'sd0,      16'sd0,      16'sh8000,   4'b0000, '0},
        '{16'sd25735,  16'sd25736,  16'sd25737,  4'b0000, '0},
        '{-16'sd25735, -16'sd25736, -16'sd25737, 4'b0000, '0},
        '{16'sd12868,  16'sd12868,  16'sd12868,  4'b0000, '0},
        '{-16'sd12868, 16'sd12868,  -16'sd12868, 4'b0000, '0},
        '{16'sd1,      -16'sd1,     16'sd1,      4'b0000, '0},
        '{16'sh5555,   16'shAAAA,   16'sh5555,   4'b0000, '0},
        '{16'sd25736,  16'sd0,      -16'sd25736, 4'b0000, '0},
        '{16'sd8192,   -16'sd8192,  16'sd16384,  4'b0000, '0},
        '{-16'sd1,     -16'sd1,     -16'sd1,     4'b0000, '0}
    };

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;   // heading_angle, attitude_angle, bank_angle
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;         // quat_w, quat_x, quat_y, quat_z

    quat_t       quat_q [$];
    bit          calm;
    int unsigned rx_hold;
    int          errors;
    int          results_seen;
    int          stall_cycles;
    int          cycles;

    euler_to_quaternion dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    // Sine and cosine of half an angle, Q2.30, by folded CORDIC rotation
    function automatic void half_trig(input angle_t ang, output longint sn,
                                      output longint cs);
        longint x, y, z, dx, dy;
        bit     flip;
        x    = ROT_GAIN;
        y    = 0;
        z    = longint'(ang) * (64'sd1 <<< Z_SHIFT);
        flip = 1'b0;
        if (z > HALF_PI_RAD) begin
            z    = z - PI_RAD;
            flip = 1'b1;
        end else if (z < -HALF_PI_RAD) begin
            z    = z + PI_RAD;
            flip = 1'b1;
        end
        for (int i = 0; i < TRIG_STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_STEP[i];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_STEP[i];
            end
        end
        cs = flip ? -x : x;
        sn = flip ? -y : y;
    endfunction

    function automatic longint qmul(input longint p, input longint r);
        return (p * r) >>> Q_FRAC;
    endfunction

    // Round half up to the output format, clamp to +-1.0
    function automatic comp_t to_comp(input longint v);
        longint r;
        r = (v + (64'sd1 <<< (RND_SHIFT - 1))) >>> RND_SHIFT;
        if (r > COMP_ONE) begin
            r = COMP_ONE;
        end else if (r < -COMP_ONE) begin
            r = -COMP_ONE;
        end
        return comp_t'(r);
    endfunction

    function automatic quat_t predict_quat(input angle_t h, input angle_t a, input angle_t b);
        longint sh, ch, sa, ca, sb, cb;
        quat_t  q;
        half_trig(h, sh, ch);
        half_trig(a, sa, ca);
        half_trig(b, sb, cb);
        q.w = to_comp(qmul(qmul(ch, ca), cb) + qmul(qmul(sh, sa), sb));
        q.x = to_comp(qmul(qmul(sh, ca), cb) - qmul(qmul(ch, sa), sb));
        q.y = to_comp(qmul(qmul(ch, sa), cb) + qmul(qmul(sh, ca), sb));
        q.z = to_comp(qmul(qmul(ch, ca), sb) - qmul(qmul(sh, sa), cb));
        return q;
    endfunction

    // Mostly full range, with weight on the fold edges, small angles and extremes
    function automatic angle_t pick_angle();
        int unsigned k;
        k = $urandom_range(99);
        if (k < 60) begin
            return angle_t'($urandom);
        end else if (k < 75) begin
            return angle_t'(($urandom_range(1) ? FOLD_EDGE : -FOLD_EDGE)
                            + int'($urandom_range(80)) - 40);
        end else if (k < 88) begin
            return angle_t'(int'($urandom_range(128)) - 64);
        end
        return $urandom_range(1) ? angle_t'(32767 - int'($urandom_range(15)))
                                 : angle_t'(-32768 + int'($urandom_range(15)));
    endfunction

    // Offer one angle triple and queue its quaternion once accepted
    task automatic send_angles(input angle_t h, input angle_t a, input angle_t b,
                               input logic [3:0] pin, input quat_t typed);
        quat_t want;
        // idle for one cycle now and then
        if (!calm && $urandom_range(99) < 18) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, a, h};
        do @(posedge aclk); while (!s_tready);
        want = predict_quat(h, a, b);
        for (int i = 0; i < 4; i++) begin
            if (pin[i]) begin
                want[i*COMPONENT_BITS +: COMPONENT_BITS] =
                    typed[i*COMPONENT_BITS +: COMPONENT_BITS];
            end
        end
        quat_q.push_back(want);
    endtask

    // Compare one result transaction with the oldest queued quaternion
    task automatic check_quat(input quat_t got);
        quat_t want;
        string fname [4];
        fname = '{"quat_w", "quat_x", "quat_y", "quat_z"};
        results_seen++;
        if (quat_q.size() == 0) begin
            $error("unexpected result transaction %h", got);
            errors++;
        end else begin
            want = quat_q.pop_front();
            for (int i = 0; i < 4; i++) begin
                if (got[i*COMPONENT_BITS +: COMPONENT_BITS] !=
                    want[i*COMPONENT_BITS +: COMPONENT_BITS]) begin
                    $error("%s: expected %0d, got %0d", fname[i],
                           comp_t'(want[i*COMPONENT_BITS +: COMPONENT_BITS]),
                           comp_t'(got[i*COMPONENT_BITS +: COMPONENT_BITS]));
                    errors++;
                end
            end
        end
    endtask

    // Result side: check, then pick the next m_tready
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                check_quat(quat_t'(m_tdata));
            end
            if (aresetn && s_tvalid && !s_tready) begin
                stall_cycles++;
            end
            if (rx_hold != 0) begin
                rx_hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= calm || ($urandom_range(99) >= 15);
            end
        end
    end

    // Watchdog
    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table
        foreach (DIR_ROWS[r]) begin
            send_angles(DIR_ROWS[r].h, DIR_ROWS[r].a, DIR_ROWS[r].b,
                        DIR_ROWS[r].pin, DIR_ROWS[r].q);
        end

        // Random triples
        for (int n = 0; n < RAND_ITEMS; n++) begin
            calm = (n >= 300 && n < 520);
            // hold the result side off long enough to fill the pipeline
            if (n == 320) begin
                rx_hold = 4 * PIPE_LAT;
            end
            // drain completely before going on
            if (n == 900) begin
                s_tvalid <= 1'b0;
                while (quat_q.size() != 0) @(posedge aclk);
            end
            send_angles(pick_angle(), pick_angle(), pick_angle(), 4'b0000, '0);
        end
        s_tvalid <= 1'b0;
        calm = 1'b0;

        // Drain, then allow stray transactions to show up
        while (quat_q.size() != 0) @(posedge aclk);
        repeat (2 * PIPE_LAT) @(posedge aclk);

        $display("Sent %0d angle triples (%0d from the table), checked %0d quaternions;",
                 N_ROWS + RAND_ITEMS, N_ROWS, results_seen);
        $display("input stalled for %0d cycles under result back-pressure, %0d mismatches",
                 stall_cycles, errors);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
src/e2q_pkg.sv
src/e2q_fold.sv
src/e2q_cordic_cell.sv
src/e2q_combine.sv
src/euler_to_quaternion.sv
verif/euler_to_quaternion_tb.sv
